>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that a condition holds at every clock edge outside reset.
`define LZX_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lzx assertion failed");

// Asserts that a trigger implies a consequence in the same cycle.
`define LZX_ASSERT_IMPLY(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("lzx implication failed");

// Asserts that a trigger implies a consequence in the next cycle.
`define LZX_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("lzx next-cycle check failed");

`endif

>>> rtl/lzx_pkg.sv
`timescale 1ns / 1ps
package lzx_pkg;

   localparam int WINDOW_SIZE      = 32768;
   localparam int WIN_AW           = $clog2(WINDOW_SIZE);
   localparam int BYTES_PER_RESULT = 8;
   localparam int CNT_W            = 3;

   localparam logic [1:0] OP_LITERAL = 2'd0;
   localparam logic [1:0] OP_MATCH   = 2'd1;
   localparam logic [1:0] OP_END     = 2'd2;
   localparam logic [1:0] OP_START   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_FAR   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_BAD_DIST  = 2'd3;

   localparam logic [15:0] ADLER_MOD = 16'd65521;

   localparam logic [8:0] LEN_BASE [0:27] = '{
      9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
      9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
      9'd115, 9'd131, 9'd163, 9'd195, 9'd227};
   localparam logic [2:0] LEN_XBITS [0:27] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5};
   localparam logic [14:0] DIST_BASE [0:29] = '{
      15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd7, 15'd9, 15'd13, 15'd17, 15'd25,
      15'd33, 15'd49, 15'd65, 15'd97, 15'd129, 15'd193, 15'd257, 15'd385, 15'd513,
      15'd769, 15'd1025, 15'd1537, 15'd2049, 15'd3073, 15'd4097, 15'd6145,
      15'd8193, 15'd12289, 15'd16385, 15'd24577};
   localparam logic [3:0] DIST_XBITS [0:29] = '{
      4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
      4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
      4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

   typedef struct packed {
      logic              we;
      logic [WIN_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [WIN_AW-1:0] raddr;
   } lzx_ram_req_type;

   function automatic logic [8:0] lzx_length(input logic [8:0] lsym, input logic [4:0] lext);
      logic [4:0] idx;
      logic [5:0] mask;
      logic [8:0] len;
      idx  = 5'd0;
      mask = 6'd0;
      len  = 9'd3;
      if (lsym >= 9'd285) begin
         len = 9'd258;
      end else if (lsym > 9'd257) begin
         idx  = 5'(lsym - 9'd257);
         mask = (6'd1 << LEN_XBITS[idx]) - 6'd1;
         len  = LEN_BASE[idx] + {4'd0, lext & mask[4:0]};
      end
      return len;
   endfunction

   function automatic logic [15:0] lzx_distance(input logic [4:0] dsym,
                                                input logic [12:0] dext);
      logic [4:0]  idx;
      logic [13:0] mask;
      idx  = (dsym >= 5'd30) ? 5'd0 : dsym;
      mask = (14'd1 << DIST_XBITS[idx]) - 14'd1;
      return {1'b0, DIST_BASE[idx]} + {3'd0, dext & mask[12:0]};
   endfunction

endpackage

>>> rtl/lzx_hist_ram.sv
`timescale 1ns / 1ps
module lzx_hist_ram
   import lzx_pkg::*;
(
   input  logic            clock,
   input  lzx_ram_req_type req,
   output logic [7:0]      rdata
);

   logic [7:0] mem [0:WINDOW_SIZE-1];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= mem[req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/lzx_adler_step.sv
`timescale 1ns / 1ps
module lzx_adler_step
   import lzx_pkg::*;
(
   input  logic [15:0] low,
   input  logic [15:0] high,
   input  logic [7:0]  data,
   output logic [15:0] low_next,
   output logic [15:0] high_next
);

   logic [16:0] low_sum;
   logic [16:0] high_sum;

   always_comb begin
      low_sum  = {1'b0, low} + {9'd0, data};
      if (low_sum >= {1'b0, ADLER_MOD}) begin
         low_sum = low_sum - {1'b0, ADLER_MOD};
      end
      low_next = low_sum[15:0];
      high_sum = {1'b0, high} + {1'b0, low_next};
      if (high_sum >= {1'b0, ADLER_MOD}) begin
         high_sum = high_sum - {1'b0, ADLER_MOD};
      end
      high_next = high_sum[15:0];
   end

endmodule

>>> rtl/deflate_lz77_token_expander.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload
// req      in         tuser: opcode[1:0]; tdata: literal, lengths, distances
// rsp      out        tuser: status[1:0]; tlast: last; tdata: bytes, counts, sums
// csr      in         data: output_capacity[31:0]
// Literal, end and start beats pass through the response state, which registers their result.
// A match passes through decode and check states; an error found in the check ends it with an error result.
// A copy moves one byte per cycle unless stalled, the window reading and writing
// in the same cycle.
// Reset is synchronous and active high; the window contents are not cleared.
// A waiting result holds the response and error paths; a copy pauses only when a full or last result cannot leave.
module deflate_lz77_token_expander
   import lzx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // literal_byte, length_symbol, length_extra, distance_symbol, distance_extra
   input  logic [39:0]  req_tdata,
   // opcode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_bytes, byte_count, checksum, produced, zero padding
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast,
   // status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_COPY   = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [7:0]  lit_ff, lit_in;
   logic [8:0]  lsym_ff, lsym_in;
   logic [4:0]  lext_ff, lext_in;
   logic [4:0]  dsym_ff, dsym_in;
   logic [12:0] dext_ff, dext_in;
   logic [8:0]  len_ff, len_in;
   logic [15:0] dist_ff, dist_in;
   logic        bad_ff, bad_in;
   logic [31:0] prod_ff, prod_in;
   logic [15:0] alow_ff, alow_in;
   logic [15:0] ahigh_ff, ahigh_in;
   logic [31:0] cap_ff, cap_in;
   logic [8:0]  iss_left_ff, iss_left_in;
   logic [8:0]  em_left_ff, em_left_in;
   logic [WIN_AW-1:0] rd_addr_ff, rd_addr_in;
   logic        rd_pend_ff, rd_pend_in;
   logic        first_ff, first_in;
   logic [7:0]  last_byte_ff, last_byte_in;
   logic [63:0] word_ff, word_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]  rsp_cnt_ff, rsp_cnt_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_sum_ff, rsp_sum_in;
   logic [31:0] rsp_prod_ff, rsp_prod_in;

   lzx_ram_req_type ram_req;
   logic [7:0]  ram_rdata;
   logic [7:0]  adler_byte;
   logic [15:0] alow_next, ahigh_next;
   logic        out_free;
   logic        completes;
   logic        stall;
   logic        emit;
   logic        issue;
   logic [7:0]  copy_byte;
   logic [1:0]  chk_status;

   lzx_hist_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   lzx_adler_step u_adler (
      .low       (alow_ff),
      .high      (ahigh_ff),
      .data      (adler_byte),
      .low_next  (alow_next),
      .high_next (ahigh_next)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'd0, rsp_prod_ff, rsp_sum_ff, rsp_cnt_ff, rsp_bytes_ff};

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign completes = (cnt_ff == CNT_W'(BYTES_PER_RESULT - 1)) || (em_left_ff == 9'd1);
   assign copy_byte = (!first_ff && (dist_ff == 16'd1)) ? last_byte_ff : ram_rdata;
   assign adler_byte = (state_ff == S_COPY) ? copy_byte : lit_ff;

   always_comb begin
      stall = 1'b0;
      if (state_ff == S_COPY) begin
         stall = rd_pend_ff && completes && !out_free;
      end
      emit  = (state_ff == S_COPY) && rd_pend_ff && !stall;
      issue = (state_ff == S_COPY) && (iss_left_ff != 9'd0) && !stall;
   end

   always_comb begin
      chk_status = ST_OK;
      if (bad_ff) begin
         chk_status = ST_BAD_DIST;
      end else if ((dist_ff > prod_ff[15:0] && prod_ff[31:16] == 16'd0)
                   || ({16'd0, dist_ff} > 32'(WINDOW_SIZE))) begin
         chk_status = ST_TOO_FAR;
      end else if (({1'b0, prod_ff} + {24'd0, len_ff}) > {1'b0, cap_ff}) begin
         chk_status = ST_OVERFLOW;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lit_in        = lit_ff;
      lsym_in       = lsym_ff;
      lext_in       = lext_ff;
      dsym_in       = dsym_ff;
      dext_in       = dext_ff;
      len_in        = len_ff;
      dist_in       = dist_ff;
      bad_in        = bad_ff;
      prod_in       = prod_ff;
      alow_in       = alow_ff;
      ahigh_in      = ahigh_ff;
      cap_in        = cap_ff;
      iss_left_in   = iss_left_ff;
      em_left_in    = em_left_ff;
      rd_addr_in    = rd_addr_ff;
      rd_pend_in    = rd_pend_ff;
      first_in      = first_ff;
      last_byte_in  = last_byte_ff;
      word_in       = word_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_prod_in   = rsp_prod_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = prod_ff[WIN_AW-1:0];
      ram_req.wdata = adler_byte;
      ram_req.re    = 1'b0;
      ram_req.raddr = rd_addr_ff;

      if (csr_valid) begin
         cap_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               lit_in  = req_tdata[7:0];
               lsym_in = req_tdata[16:8];
               lext_in = req_tdata[21:17];
               dsym_in = req_tdata[26:22];
               dext_in = req_tdata[39:27];
               state_in = (req_tuser == OP_MATCH) ? S_DECODE : S_RESP;
            end
         end
         S_DECODE: begin
            len_in   = lzx_length(lsym_ff, lext_ff);
            dist_in  = lzx_distance(dsym_ff, dext_ff);
            bad_in   = (dsym_ff >= 5'd30);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (chk_status != ST_OK) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_bytes_in  = 64'd0;
                  rsp_cnt_in    = 4'd0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = chk_status;
                  rsp_sum_in    = {ahigh_ff, alow_ff};
                  rsp_prod_in   = prod_ff;
                  state_in      = S_IDLE;
               end
            end else begin
               iss_left_in = len_ff;
               em_left_in  = len_ff;
               rd_addr_in  = prod_ff[WIN_AW-1:0] - dist_ff[WIN_AW-1:0];
               rd_pend_in  = 1'b0;
               first_in    = 1'b1;
               word_in     = 64'd0;
               cnt_in      = '0;
               state_in    = S_COPY;
            end
         end
         S_COPY: begin
            if (issue) begin
               ram_req.re  = 1'b1;
               rd_addr_in  = rd_addr_ff + 1'b1;
               iss_left_in = iss_left_ff - 9'd1;
               rd_pend_in  = 1'b1;
            end else if (emit) begin
               rd_pend_in = 1'b0;
            end
            if (emit) begin
               ram_req.we   = 1'b1;
               first_in     = 1'b0;
               last_byte_in = copy_byte;
               alow_in      = alow_next;
               ahigh_in     = ahigh_next;
               prod_in      = prod_ff + 32'd1;
               em_left_in   = em_left_ff - 9'd1;
               word_in      = word_ff | ({56'd0, copy_byte} << {cnt_ff, 3'b000});
               cnt_in       = cnt_ff + 1'b1;
               if (completes) begin
                  rsp_valid_in  = 1'b1;
                  rsp_bytes_in  = word_ff | ({56'd0, copy_byte} << {cnt_ff, 3'b000});
                  rsp_cnt_in    = {1'b0, cnt_ff} + 4'd1;
                  rsp_last_in   = (em_left_ff == 9'd1);
                  rsp_status_in = ST_OK;
                  rsp_sum_in    = {ahigh_next, alow_next};
                  rsp_prod_in   = prod_ff + 32'd1;
                  word_in       = 64'd0;
                  cnt_in        = '0;
                  if (em_left_ff == 9'd1) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bytes_in  = 64'd0;
               rsp_cnt_in    = 4'd0;
               rsp_last_in   = 1'b1;
               rsp_status_in = ST_OK;
               rsp_sum_in    = {ahigh_ff, alow_ff};
               rsp_prod_in   = prod_ff;
               state_in      = S_IDLE;
               case (op_ff)
                  OP_LITERAL: begin
                     if (prod_ff >= cap_ff) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        ram_req.we   = 1'b1;
                        alow_in      = alow_next;
                        ahigh_in     = ahigh_next;
                        prod_in      = prod_ff + 32'd1;
                        rsp_bytes_in = {56'd0, lit_ff};
                        rsp_cnt_in   = 4'd1;
                        rsp_sum_in   = {ahigh_next, alow_next};
                        rsp_prod_in  = prod_ff + 32'd1;
                     end
                  end
                  OP_START: begin
                     prod_in     = 32'd0;
                     alow_in     = 16'd1;
                     ahigh_in    = 16'd0;
                     rsp_sum_in  = 32'd1;
                     rsp_prod_in = 32'd0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prod_ff      <= 32'd0;
         alow_ff      <= 16'd1;
         ahigh_ff     <= 16'd0;
         cap_ff       <= 32'hFFFF_FFFF;
         iss_left_ff  <= 9'd0;
         em_left_ff   <= 9'd0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prod_ff      <= prod_in;
         alow_ff      <= alow_in;
         ahigh_ff     <= ahigh_in;
         cap_ff       <= cap_in;
         iss_left_ff  <= iss_left_in;
         em_left_ff   <= em_left_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      lit_ff        <= lit_in;
      lsym_ff       <= lsym_in;
      lext_ff       <= lext_in;
      dsym_ff       <= dsym_in;
      dext_ff       <= dext_in;
      len_ff        <= len_in;
      dist_ff       <= dist_in;
      bad_ff        <= bad_in;
      rd_addr_ff    <= rd_addr_in;
      first_ff      <= first_in;
      last_byte_ff  <= last_byte_in;
      word_ff       <= word_in;
      cnt_ff        <= cnt_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_prod_ff   <= rsp_prod_in;
   end

endmodule

>>> rtl/lzx_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lzx_checker
   import lzx_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tlast,
   input logic [1:0]   rsp_tuser
);

   `LZX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `LZX_ASSERT_IMPLY(a_err_empty, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tlast && (rsp_tdata[67:64] == 4'd0))
   `LZX_ASSERT_IMPLY(a_mid_full, clock, reset, rsp_tvalid && !rsp_tlast, (rsp_tdata[67:64] == 4'd8) && (rsp_tuser == ST_OK))
   `LZX_ASSERT_ALWAYS(a_count_range, clock, reset, !rsp_tvalid || (rsp_tdata[67:64] <= 4'd8))

endmodule

bind deflate_lz77_token_expander lzx_checker u_lzx_checker (.*);
